// ===== hdl/pedal_command_link_macros.svh =====
// Assertion macros of the pedal command link RTL.
`ifndef PEDAL_COMMAND_LINK_MACROS_SVH
`define PEDAL_COMMAND_LINK_MACROS_SVH

`ifndef ASSERT_OFF

// Checked only while the block is out of reset.
`define PCL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("pedal_command_link assertion failed");

// Checked at every edge, reset included.
`define PCL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("pedal_command_link assertion failed");

`else

`define PCL_ASSERT(lbl, clk, rstn, prop)
`define PCL_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hdl/pcl_pkg.sv =====
// Types, constants and CRC helpers of the pedal command link.
`timescale 1ns / 1ps

package pcl_pkg;

    localparam int MSG_W = 40;

    localparam logic [10:0] CMD_ID      = 11'h100;
    localparam logic [7:0]  CRC_POLY    = 8'hD5;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam int          ENABLE_BIT  = 7;
    localparam logic [7:0]  LIMIT_RESET = 8'd10;

    localparam logic [1:0] ACT_FRAME = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_BUS   = 2'd2;

    localparam logic [2:0] FAULT_NONE     = 3'd0;
    localparam logic [2:0] FAULT_CHECKSUM = 3'd1;
    localparam logic [2:0] FAULT_MAILBOX  = 3'd2;
    localparam logic [2:0] FAULT_BUS      = 3'd3;
    localparam logic [2:0] FAULT_POWER_UP = 3'd4;
    localparam logic [2:0] FAULT_SILENT   = 3'd5;
    localparam logic [2:0] FAULT_BAD_CMD  = 3'd6;

    typedef struct packed {
        logic [1:0]  action;
        logic [10:0] frame_id;
        logic [15:0] rx_value_0;
        logic [15:0] rx_value_1;
        logic [7:0]  rx_control;
        logic [7:0]  rx_check;
        logic        tx_free;
        logic [15:0] pedal_0;
        logic [15:0] pedal_1;
    } pcl_in_t;

    typedef struct packed {
        logic        send_valid;
        logic [15:0] tx_value_0;
        logic [15:0] tx_value_1;
        logic [7:0]  tx_status;
        logic [7:0]  tx_check;
        logic [15:0] gas_out_0;
        logic [15:0] gas_out_1;
        logic [2:0]  fault_out;
    } pcl_out_t;

    // Bit-serial CRC, MSB of the message first. Only evaluated on constants.
    function automatic logic [7:0] crc8_serial(input logic [MSG_W-1:0] msg);
        logic [7:0] c;
        logic       fb;
        c = CRC_INIT;
        for (int i = MSG_W - 1; i >= 0; i--) begin
            fb = c[7] ^ msg[i];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // The CRC is affine in the message, so each message bit flips a fixed
    // pattern of CRC bits on top of the all-zero message's CRC.
    function automatic logic [MSG_W-1:0][7:0] crc8_columns();
        logic [MSG_W-1:0][7:0] cols;
        logic [7:0]            base;
        base = crc8_serial('0);
        for (int i = 0; i < MSG_W; i++) begin
            cols[i] = crc8_serial(MSG_W'(1) << i) ^ base;
        end
        return cols;
    endfunction

    // Frame bytes 4 down to 0 in the order the CRC consumes them.
    function automatic logic [MSG_W-1:0] frame_msg(input logic [15:0] w0,
                                                   input logic [15:0] w1,
                                                   input logic [7:0]  b4);
        return {b4, w1[7:0], w1[15:8], w0[7:0], w0[15:8]};
    endfunction

endpackage

// ===== hdl/pcl_crc8.sv =====
// Parallel CRC-8 over a five-byte frame, as an XOR network of constant columns.
`timescale 1ns / 1ps

module pcl_crc8 (
    input  logic [pcl_pkg::MSG_W-1:0] msg,
    output logic [7:0]                crc
);

    localparam logic [7:0] CRC_BASE = pcl_pkg::crc8_serial('0);
    localparam logic [pcl_pkg::MSG_W-1:0][7:0] CRC_COLS = pcl_pkg::crc8_columns();

    always_comb begin
        crc = CRC_BASE;
        for (int i = 0; i < pcl_pkg::MSG_W; i++) begin
            if (msg[i]) begin
                crc = crc ^ CRC_COLS[i];
            end
        end
    end

endmodule

// ===== hdl/pcl_core.sv =====
// Link state, timeout register and the per-word update and result logic.
`timescale 1ns / 1ps

module pcl_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data,
    input  logic              step,
    input  pcl_pkg::pcl_in_t  item,
    output pcl_pkg::pcl_out_t result
);

    logic [7:0]  limit_reg;
    logic [15:0] gas0_reg, gas0_next;
    logic [15:0] gas1_reg, gas1_next;
    logic [2:0]  fault_reg, fault_next;
    logic [7:0]  silence_reg, silence_next;
    logic [3:0]  rx_seq_reg, rx_seq_next;
    logic [3:0]  tx_seq_reg, tx_seq_next;

    logic [7:0] rx_crc;
    logic [7:0] tx_crc;
    logic [7:0] status;
    logic [3:0] seq;

    assign seq    = item.rx_control[3:0];
    assign status = {1'b0, fault_reg, tx_seq_reg};

    pcl_crc8 u_rx_crc (
        .msg (pcl_pkg::frame_msg(item.rx_value_0, item.rx_value_1, item.rx_control)),
        .crc (rx_crc)
    );

    pcl_crc8 u_tx_crc (
        .msg (pcl_pkg::frame_msg(item.pedal_0, item.pedal_1, status)),
        .crc (tx_crc)
    );

    always_comb begin
        gas0_next    = gas0_reg;
        gas1_next    = gas1_reg;
        fault_next   = fault_reg;
        silence_next = silence_reg;
        rx_seq_next  = rx_seq_reg;
        tx_seq_next  = tx_seq_reg;
        result       = '0;

        unique case (item.action)
            pcl_pkg::ACT_FRAME: begin
                if (item.frame_id == pcl_pkg::CMD_ID) begin
                    if (rx_crc == item.rx_check) begin
                        if (4'(rx_seq_reg + 4'd1) == seq) begin
                            if (item.rx_control[pcl_pkg::ENABLE_BIT]) begin
                                gas0_next = item.rx_value_0;
                                gas1_next = item.rx_value_1;
                            end else begin
                                fault_next = (item.rx_value_0 == '0 && item.rx_value_1 == '0)
                                           ? pcl_pkg::FAULT_NONE : pcl_pkg::FAULT_BAD_CMD;
                                gas0_next  = '0;
                                gas1_next  = '0;
                            end
                            silence_next = '0;
                        end
                        rx_seq_next = seq;
                    end else begin
                        fault_next = pcl_pkg::FAULT_CHECKSUM;
                    end
                end
            end
            pcl_pkg::ACT_TICK: begin
                if (item.tx_free) begin
                    result.send_valid = 1'b1;
                    result.tx_value_0 = item.pedal_0;
                    result.tx_value_1 = item.pedal_1;
                    result.tx_status  = status;
                    result.tx_check   = tx_crc;
                    tx_seq_next       = 4'(tx_seq_reg + 4'd1);
                end else begin
                    fault_next = pcl_pkg::FAULT_MAILBOX;
                end
                // The count saturates at the limit, so a lowered limit bites at once.
                if (silence_reg >= limit_reg) begin
                    fault_next = pcl_pkg::FAULT_SILENT;
                end else begin
                    silence_next = 8'(silence_reg + 8'd1);
                end
            end
            pcl_pkg::ACT_BUS: begin
                fault_next = pcl_pkg::FAULT_BUS;
            end
            default: begin
            end
        endcase

        result.gas_out_0 = gas0_next;
        result.gas_out_1 = gas1_next;
        result.fault_out = fault_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= pcl_pkg::LIMIT_RESET;
            gas0_reg    <= '0;
            gas1_reg    <= '0;
            fault_reg   <= pcl_pkg::FAULT_POWER_UP;
            silence_reg <= '0;
            rx_seq_reg  <= '0;
            tx_seq_reg  <= '0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_data;
            end
            if (step) begin
                gas0_reg    <= gas0_next;
                gas1_reg    <= gas1_next;
                fault_reg   <= fault_next;
                silence_reg <= silence_next;
                rx_seq_reg  <= rx_seq_next;
                tx_seq_reg  <= tx_seq_next;
            end
        end
    end

endmodule

// ===== hdl/pedal_command_link.sv =====
// Top level of the pedal command link: input and result registers around the core.
//
//  Channel  Ports                        Width  Role
//  s_       s_valid s_ready s_data       94     frame, tick or bus-error word in
//  m_       m_valid m_ready m_data       84     one result word per input word
//  cfg_     cfg_valid cfg_ready cfg_data 8      timeout limit write, always ready
//
// One word per cycle unless m_ready stalls; m_valid follows the result register.
// The whole update is one pass from the input register to the result register.
// Reset is synchronous on aresetn low; no clearing pass is needed.
// A stalled m_ side holds the result register and the input register fills;
// s_ready then drops until the result word is taken.
`timescale 1ns / 1ps
`include "pedal_command_link_macros.svh"

module pedal_command_link (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pcl_pkg::pcl_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pcl_pkg::pcl_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);

    pcl_pkg::pcl_in_t  in_data_reg;
    logic              in_valid_reg;
    pcl_pkg::pcl_out_t out_data_reg;
    logic              out_valid_reg;
    pcl_pkg::pcl_out_t core_result;
    logic              advance;

    // A word moves on once the result register is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    pcl_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .step     (advance),
        .item     (in_data_reg),
        .result   (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    `PCL_ASSERT(a_advance_fills_out, aclk, aresetn, advance |=> out_valid_reg)
    `PCL_ASSERT(a_held_word_kept, aclk, aresetn,
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
    `PCL_ASSERT(a_fault_code_known, aclk, aresetn,
        out_valid_reg |-> (out_data_reg.fault_out != 3'd7))
    `PCL_ASSERT(a_quiet_frame_zero, aclk, aresetn,
        (out_valid_reg && !out_data_reg.send_valid) |->
        (out_data_reg.tx_value_0 == '0 && out_data_reg.tx_value_1 == '0 &&
         out_data_reg.tx_status == '0 && out_data_reg.tx_check == '0))
    `PCL_ASSERT_ALWAYS(a_reset_empties, aclk,
        !aresetn |=> (!in_valid_reg && !out_valid_reg))

endmodule

// ===== sim/tb_pedal_command_link.sv =====
// Self-checking testbench for pedal_command_link: directed table, then random words.
`timescale 1ns / 1ps

module tb_pedal_command_link;

    localparam logic [1:0] ACT_SPARE   = 2'd3;
    localparam int         IN_W        = $bits(pcl_pkg::pcl_in_t);
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         LONG_HOLD   = 300;
    localparam int         PHASES      = 6;
    localparam int         PHASE_WORDS = 210;

    typedef struct {
        pcl_pkg::pcl_in_t  word;
        bit                typed;
        pcl_pkg::pcl_out_t result;
    } dir_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    pcl_pkg::pcl_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    pcl_pkg::pcl_out_t m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_data = '0;

    // Predicted state of the link.
    logic [15:0] gas_a = '0;
    logic [15:0] gas_b = '0;
    logic [2:0]  fault_now = pcl_pkg::FAULT_POWER_UP;
    logic [7:0]  quiet_ticks = '0;
    logic [3:0]  seen_seq = '0;
    logic [3:0]  status_seq = '0;
    logic [7:0]  limit_now = pcl_pkg::LIMIT_RESET;

    pcl_pkg::pcl_out_t expected_words[$];
    dir_row_t          directed_rows[$];
    bit                typed_valid = 1'b0;
    pcl_pkg::pcl_out_t typed_word = '0;
    bit                idle_on = 1'b1;
    bit                hold_request = 1'b0;
    int                mismatches = 0;
    int                cycle_count = 0;

    pedal_command_link u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] v;
        v = c ^ b;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ((v << 1) ^ pcl_pkg::CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

    // Bytes are consumed from byte 4 down to byte 0, high byte of each value last.
    function automatic logic [7:0] frame_crc(input logic [15:0] w0, input logic [15:0] w1,
                                             input logic [7:0] b4);
        logic [7:0] c;
        c = crc_step(pcl_pkg::CRC_INIT, b4);
        c = crc_step(c, w1[7:0]);
        c = crc_step(c, w1[15:8]);
        c = crc_step(c, w0[7:0]);
        return crc_step(c, w0[15:8]);
    endfunction

    function automatic pcl_pkg::pcl_out_t predict_link(input pcl_pkg::pcl_in_t w);
        pcl_pkg::pcl_out_t r;
        logic [3:0]        seq;
        logic [7:0]        st;
        r = '0;
        seq = w.rx_control[3:0];
        unique case (w.action)
            pcl_pkg::ACT_FRAME: begin
                if (w.frame_id == pcl_pkg::CMD_ID) begin
                    if (frame_crc(w.rx_value_0, w.rx_value_1, w.rx_control) == w.rx_check) begin
                        if (4'(seen_seq + 4'd1) == seq) begin
                            if (w.rx_control[pcl_pkg::ENABLE_BIT]) begin
                                gas_a = w.rx_value_0;
                                gas_b = w.rx_value_1;
                            end else begin
                                fault_now = (w.rx_value_0 == 16'd0 && w.rx_value_1 == 16'd0)
                                            ? pcl_pkg::FAULT_NONE : pcl_pkg::FAULT_BAD_CMD;
                                gas_a = '0;
                                gas_b = '0;
                            end
                            quiet_ticks = '0;
                        end
                        seen_seq = seq;
                    end else begin
                        fault_now = pcl_pkg::FAULT_CHECKSUM;
                    end
                end
            end
            pcl_pkg::ACT_TICK: begin
                // The status word carries the fault as it stood before the timeout update.
                if (w.tx_free) begin
                    st = {1'b0, fault_now, status_seq};
                    r.send_valid = 1'b1;
                    r.tx_value_0 = w.pedal_0;
                    r.tx_value_1 = w.pedal_1;
                    r.tx_status  = st;
                    r.tx_check   = frame_crc(w.pedal_0, w.pedal_1, st);
                    status_seq   = status_seq + 4'd1;
                end else begin
                    fault_now = pcl_pkg::FAULT_MAILBOX;
                end
                if (quiet_ticks >= limit_now) begin
                    fault_now = pcl_pkg::FAULT_SILENT;
                end else begin
                    quiet_ticks = quiet_ticks + 8'd1;
                end
            end
            pcl_pkg::ACT_BUS: begin
                fault_now = pcl_pkg::FAULT_BUS;
            end
            default: begin
            end
        endcase
        r.gas_out_0 = gas_a;
        r.gas_out_1 = gas_b;
        r.fault_out = fault_now;
        return r;
    endfunction

    function automatic string describe(input pcl_pkg::pcl_out_t r);
        return $sformatf("send=%0b tx=%h/%h status=%h crc=%h gas=%h/%h fault=%0d",
                         r.send_valid, r.tx_value_0, r.tx_value_1, r.tx_status,
                         r.tx_check, r.gas_out_0, r.gas_out_1, r.fault_out);
    endfunction

    function automatic void compare_word(input pcl_pkg::pcl_out_t e,
                                         input pcl_pkg::pcl_out_t a);
        bit bad;
        bad = (e.send_valid !== a.send_valid) || (e.tx_value_0 !== a.tx_value_0) ||
              (e.tx_value_1 !== a.tx_value_1) || (e.tx_status !== a.tx_status) ||
              (e.tx_check !== a.tx_check) || (e.gas_out_0 !== a.gas_out_0) ||
              (e.gas_out_1 !== a.gas_out_1) || (e.fault_out !== a.fault_out);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result mismatch at cycle %0d", cycle_count);
                $display("  expected %s", describe(e));
                $display("  actual   %s", describe(a));
            end
        end
    endfunction

    // Monitor: results are checked before the word accepted on the same edge is predicted.
    always @(posedge aclk) begin : monitor
        pcl_pkg::pcl_out_t predicted;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result word: %s", describe(m_data));
                    end
                end else begin
                    compare_word(expected_words.pop_front(), m_data);
                end
            end
            if (cfg_valid && cfg_ready) begin
                limit_now = cfg_data;
            end
            if (s_valid && s_ready) begin
                predicted = predict_link(s_data);
                expected_words.push_back(typed_valid ? typed_word : predicted);
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off when requested.
    initial begin : receiver
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                stall = $urandom_range(1, 15);
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic push_word(input pcl_pkg::pcl_in_t w, input bit typed,
                             input pcl_pkg::pcl_out_t r);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_data = w;
        s_valid = 1'b1;
        typed_valid = typed;
        typed_word = r;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        typed_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        wait_drained();
        repeat (4) @(negedge aclk);
        cfg_data = v;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic pcl_pkg::pcl_in_t cmd_word(input logic [10:0] id,
                                                  input logic [15:0] v0,
                                                  input logic [15:0] v1,
                                                  input logic [7:0]  ctrl,
                                                  input logic [7:0]  spoil);
        pcl_pkg::pcl_in_t w;
        w = '0;
        w.action = pcl_pkg::ACT_FRAME;
        w.frame_id = id;
        w.rx_value_0 = v0;
        w.rx_value_1 = v1;
        w.rx_control = ctrl;
        w.rx_check = frame_crc(v0, v1, ctrl) ^ spoil;
        return w;
    endfunction

    function automatic pcl_pkg::pcl_in_t tick_word(input logic free, input logic [15:0] p0,
                                                   input logic [15:0] p1);
        pcl_pkg::pcl_in_t w;
        w = '0;
        w.action = pcl_pkg::ACT_TICK;
        w.tx_free = free;
        w.pedal_0 = p0;
        w.pedal_1 = p1;
        return w;
    endfunction

    // Typed rows all leave the setpoints at zero and emit no status word.
    function automatic void add_row(input pcl_pkg::pcl_in_t w, input bit typed,
                                    input logic [2:0] f);
        dir_row_t row;
        row.word = w;
        row.typed = typed;
        row.result = '0;
        row.result.fault_out = f;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [15:0] pick_level();
        unique case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Commands that follow the sequence counter are the largest share, so latching and clearing are reached.
    function automatic pcl_pkg::pcl_in_t random_word();
        pcl_pkg::pcl_in_t w;
        int               pick;
        w = IN_W'({$urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 48) begin
            w.action = pcl_pkg::ACT_FRAME;
            w.frame_id = pcl_pkg::CMD_ID;
            w.rx_value_0 = pick_level();
            w.rx_value_1 = pick_level();
            if (pick < 40) begin
                w.rx_control[3:0] = seen_seq + 4'd1;
                w.rx_control[pcl_pkg::ENABLE_BIT] = ($urandom_range(0, 3) != 0);
                if (!w.rx_control[pcl_pkg::ENABLE_BIT] && $urandom_range(0, 1) == 1) begin
                    w.rx_value_0 = '0;
                    w.rx_value_1 = '0;
                end
            end else begin
                w.rx_control[3:0] = seen_seq + 4'($urandom_range(2, 16));
            end
            w.rx_check = frame_crc(w.rx_value_0, w.rx_value_1, w.rx_control);
        end else if (pick < 54) begin
            w.action = pcl_pkg::ACT_FRAME;
            w.frame_id = pcl_pkg::CMD_ID;
            w.rx_check = frame_crc(w.rx_value_0, w.rx_value_1, w.rx_control)
                         ^ 8'($urandom_range(1, 255));
        end else if (pick < 58) begin
            w.action = pcl_pkg::ACT_FRAME;
            if (w.frame_id == pcl_pkg::CMD_ID) begin
                w.frame_id[0] = 1'b1;
            end
        end else if (pick < 88) begin
            w.action = pcl_pkg::ACT_TICK;
            w.tx_free = ($urandom_range(0, 6) != 0);
            w.pedal_0 = pick_level();
            w.pedal_1 = pick_level();
        end else if (pick < 94) begin
            w.action = pcl_pkg::ACT_BUS;
        end else begin
            w.action = ACT_SPARE;
        end
        return w;
    endfunction

    initial begin : stimulus
        pcl_pkg::pcl_in_t w;
        logic [7:0]       limits [PHASES];
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        w = '1;
        w.action = ACT_SPARE;
        add_row(w, 1'b1, pcl_pkg::FAULT_POWER_UP);
        w.action = pcl_pkg::ACT_FRAME;
        add_row(w, 1'b1, pcl_pkg::FAULT_POWER_UP);
        add_row('0, 1'b1, pcl_pkg::FAULT_POWER_UP);
        add_row(cmd_word(pcl_pkg::CMD_ID, 16'hFFFF, 16'hFFFF, 8'h81, 8'h80), 1'b1,
                pcl_pkg::FAULT_CHECKSUM);
        w.action = pcl_pkg::ACT_BUS;
        add_row(w, 1'b1, pcl_pkg::FAULT_BUS);
        add_row(tick_word(1'b1, 16'hFFFF, 16'hFFFF), 1'b0, pcl_pkg::FAULT_NONE);
        add_row(tick_word(1'b1, 16'h0000, 16'h0000), 1'b0, pcl_pkg::FAULT_NONE);
        add_row(tick_word(1'b0, 16'h1234, 16'h4321), 1'b0, pcl_pkg::FAULT_NONE);
        add_row(cmd_word(pcl_pkg::CMD_ID, 16'hFFFF, 16'hFFFF, 8'h81, 8'h00), 1'b0,
                pcl_pkg::FAULT_NONE);
        add_row(cmd_word(pcl_pkg::CMD_ID, 16'h0000, 16'h0000, 8'hF2, 8'h00), 1'b0,
                pcl_pkg::FAULT_NONE);
        add_row(cmd_word(pcl_pkg::CMD_ID, 16'h1234, 16'h5678, 8'h89, 8'h00), 1'b0,
                pcl_pkg::FAULT_NONE);
        add_row(cmd_word(pcl_pkg::CMD_ID, 16'h0000, 16'h0000, 8'h0A, 8'h00), 1'b1,
                pcl_pkg::FAULT_NONE);
        add_row(cmd_word(pcl_pkg::CMD_ID, 16'h8000, 16'h0000, 8'h0B, 8'h00), 1'b1,
                pcl_pkg::FAULT_BAD_CMD);
        add_row(cmd_word(pcl_pkg::CMD_ID, 16'h0000, 16'h0001, 8'h0C, 8'h00), 1'b1,
                pcl_pkg::FAULT_BAD_CMD);
        add_row(cmd_word(pcl_pkg::CMD_ID, 16'h5555, 16'hAAAA, 8'h8D, 8'h00), 1'b0,
                pcl_pkg::FAULT_NONE);
        add_row(cmd_word(pcl_pkg::CMD_ID, 16'h0F0F, 16'hF0F0, 8'h8E, 8'h00), 1'b0,
                pcl_pkg::FAULT_NONE);
        add_row(cmd_word(pcl_pkg::CMD_ID, 16'h00FF, 16'hFF00, 8'h8F, 8'h00), 1'b0,
                pcl_pkg::FAULT_NONE);
        // Counter wraps from 15 to 0, then a repeat of the same counter is refused.
        add_row(cmd_word(pcl_pkg::CMD_ID, 16'hAAAA, 16'h5555, 8'h80, 8'h00), 1'b0,
                pcl_pkg::FAULT_NONE);
        add_row(cmd_word(pcl_pkg::CMD_ID, 16'h1111, 16'h2222, 8'h80, 8'h00), 1'b0,
                pcl_pkg::FAULT_NONE);
        add_row(cmd_word(11'h101, 16'h3333, 16'h4444, 8'h81, 8'h00), 1'b0,
                pcl_pkg::FAULT_NONE);
        add_row(tick_word(1'b1, 16'h8000, 16'h0001), 1'b0, pcl_pkg::FAULT_NONE);
        add_row(tick_word(1'b1, 16'h7FFF, 16'hFFFE), 1'b0, pcl_pkg::FAULT_NONE);
        foreach (directed_rows[i]) begin
            push_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);
        end

        limits = '{8'd0, 8'd255, 8'd3, 8'($urandom_range(4, 254)), 8'd1,
                   pcl_pkg::LIMIT_RESET};
        for (int p = 0; p < PHASES; p++) begin
            write_limit(limits[p]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                idle_on = (p != PHASES - 1) && ((n / 40) % 3 != 2);
                if (p == 2 && n == 50) begin
                    hold_request = 1'b1;
                end
                if (p == 1 && n == 100) begin
                    wait_drained();
                end
                push_word(random_word(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
